// File: hdl/pmuca_pkg.sv
// pmuca_pkg: shared constants and types for the pmu counter assignment block
// used by pmuca_pack_unit and pmu_counter_assign_and_program; no dependencies
`timescale 1ns / 1ps

package pmuca_pkg;

    // event set capacity
    localparam int MAX_EVENTS = 6;
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
    localparam int IDX_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    // field widths
    localparam int EVENT_W    = 50;
    localparam int CIDX_W     = 4;
    localparam int MMCR0_W    = 32;
    localparam int MMCR1_W    = 64;
    localparam int MMCRA_W    = 64;
    localparam int INUSE_W    = 16;

    // stream data widths, padded to whole bytes
    localparam int S_DATA_W   = ((EVENT_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CIDX_W + MMCR0_W + MMCR1_W + MMCRA_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // fabric match detection on the low event code bits
    localparam logic [19:0] FAB_MASK   = 20'hff0fe;
    localparam logic [19:0] FAB_CODE_A = 20'h30056;
    localparam logic [19:0] FAB_CODE_B = 20'h4f052;

    // counter in-use groups for mmcr0
    localparam logic [INUSE_W-1:0] INUSE_2TO6_MASK = 16'h007c;
    localparam logic [INUSE_W-1:0] INUSE_5TO6_MASK = 16'h0060;

    // mmcra starts with bit 42 set
    localparam logic [MMCRA_W-1:0] MMCRA_INIT = 64'h0000_0400_0000_0000;

    // counter used when every general counter is taken
    localparam logic [CIDX_W-1:0] FALLBACK_COUNTER = 4'd5;

    // running state of the packing pass
    typedef struct packed {
        logic [INUSE_W-1:0] inuse;
        logic [MMCR1_W-1:0] mmcr1;
        logic [MMCRA_W-1:0] mmcra;
    } pack_acc_t;

endpackage

// File: hdl/pmuca_pack_unit.sv
// pmuca_pack_unit: shared step unit, assigns one event's counter and folds
// its fields into the control register images; depends on pmuca_pkg
`timescale 1ns / 1ps

module pmuca_pack_unit (
    input  logic [pmuca_pkg::EVENT_W-1:0] event_code,
    input  pmuca_pkg::pack_acc_t          acc_in,
    output pmuca_pkg::pack_acc_t          acc_out,
    output logic [pmuca_pkg::CIDX_W-1:0]  counter_index,
    output logic [pmuca_pkg::MMCR0_W-1:0] mmcr0_image
);

    logic [pmuca_pkg::CIDX_W-1:0] p_field;
    logic [pmuca_pkg::CIDX_W-1:0] p;
    logic [3:0]                   unit;
    logic                         comb;
    logic [7:0]                   sel;
    logic [4:0]                   smode;
    logic                         fab;

    assign p_field = event_code[19:16];
    assign unit    = event_code[15:12];
    assign comb    = event_code[11];
    assign sel     = event_code[7:0];
    assign smode   = event_code[28:24];
    assign fab     = ((event_code[19:0] & pmuca_pkg::FAB_MASK) == pmuca_pkg::FAB_CODE_A) ||
                     ((event_code[19:0] & pmuca_pkg::FAB_MASK) == pmuca_pkg::FAB_CODE_B);

    // counter choice: named counter, else lowest free of 1..4, else fallback
    always_comb begin
        if (p_field != '0) begin
            p = p_field;
        end else if (!acc_in.inuse[1]) begin
            p = 4'd1;
        end else if (!acc_in.inuse[2]) begin
            p = 4'd2;
        end else if (!acc_in.inuse[3]) begin
            p = 4'd3;
        end else if (!acc_in.inuse[4]) begin
            p = 4'd4;
        end else begin
            p = pmuca_pkg::FALLBACK_COUNTER;
        end
    end

    assign counter_index = p - 4'd1;

    // fold the event into the images
    always_comb begin
        acc_out       = acc_in;
        acc_out.inuse = acc_in.inuse | (16'(1) << p);

        // per-counter unit, combine and select
        case (p)
            4'd1: begin
                acc_out.mmcr1[63:60] = acc_in.mmcr1[63:60] | unit;
                acc_out.mmcr1[35]    = acc_in.mmcr1[35] | comb;
                acc_out.mmcr1[31:24] = acc_in.mmcr1[31:24] | sel;
            end
            4'd2: begin
                acc_out.mmcr1[59:56] = acc_in.mmcr1[59:56] | unit;
                acc_out.mmcr1[34]    = acc_in.mmcr1[34] | comb;
                acc_out.mmcr1[23:16] = acc_in.mmcr1[23:16] | sel;
            end
            4'd3: begin
                acc_out.mmcr1[55:52] = acc_in.mmcr1[55:52] | unit;
                acc_out.mmcr1[33]    = acc_in.mmcr1[33] | comb;
                acc_out.mmcr1[15:8]  = acc_in.mmcr1[15:8] | sel;
            end
            4'd4: begin
                acc_out.mmcr1[51:48] = acc_in.mmcr1[51:48] | unit;
                acc_out.mmcr1[32]    = acc_in.mmcr1[32] | comb;
                acc_out.mmcr1[7:0]   = acc_in.mmcr1[7:0] | sel;
            end
            default: begin
            end
        endcase

        // cache qualifiers
        if (event_code[22]) begin
            acc_out.mmcr1[46] = acc_in.mmcr1[46] | event_code[20];
            acc_out.mmcr1[47] = acc_in.mmcr1[47] | event_code[21];
        end

        // sampling
        if (event_code[8]) begin
            acc_out.mmcra[0] = 1'b1;
            if (smode != '0) begin
                acc_out.mmcra[2:1] = acc_in.mmcra[2:1] | smode[1:0];
                acc_out.mmcra[6:4] = acc_in.mmcra[6:4] | smode[4:2];
            end
        end

        // threshold or fabric match
        if (fab) begin
            acc_out.mmcr1[43:36] = acc_in.mmcr1[43:36] | event_code[39:32];
        end else begin
            acc_out.mmcra[15:8]  = acc_in.mmcra[15:8] | event_code[39:32];
            acc_out.mmcra[18:16] = acc_in.mmcra[18:16] | event_code[31:29];
            acc_out.mmcra[41:32] = acc_in.mmcra[41:32] | event_code[49:40];
        end
    end

    // mmcr0 from the updated in-use set
    always_comb begin
        mmcr0_image     = '0;
        mmcr0_image[15] = acc_out.inuse[1];
        mmcr0_image[14] = |(acc_out.inuse & pmuca_pkg::INUSE_2TO6_MASK);
        mmcr0_image[4]  = ~|(acc_out.inuse & pmuca_pkg::INUSE_5TO6_MASK);
    end

endmodule

// File: hdl/pmu_counter_assign_and_program.sv
// pmu_counter_assign_and_program: event buffer, sequencer and result register
// depends on pmuca_pkg and pmuca_pack_unit
`timescale 1ns / 1ps
//
// channel  dir  transfer contents
// -------  ---  -------------------------------------------------------------
// s_       in   one event code; tlast ends the event set
// m_       out  one result per buffered event; tlast on the set's final one
//
// an event that does not end the set is only stored in the event buffer
// the ending event starts a mark pass that visits the buffered events one per step,
// then per event a pack step in the shared unit and an output step that holds
// until the result is taken
// s_tready is low from the ending event until the final result is taken
// reset clears the sequencer and the event count; the event buffer needs no clearing

module pmu_counter_assign_and_program (
    input  logic                            aclk,
    input  logic                            aresetn,
    // event_code
    input  logic [pmuca_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // counter_index, mmcr0_image, mmcr1_image, mmcra_image, too_many
    output logic [pmuca_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    typedef enum logic [1:0] {
        S_COLLECT,
        S_MARK,
        S_PACK,
        S_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [pmuca_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                               ovf_reg, ovf_next;
    logic [pmuca_pkg::CNT_W-1:0]        n_reg, n_next;
    logic [pmuca_pkg::IDX_W-1:0]        idx_reg, idx_next;
    pmuca_pkg::pack_acc_t               acc_reg, acc_next;
    logic                               valid_reg, valid_next;
    logic                               last_reg, last_next;
    logic [pmuca_pkg::M_DATA_W-1:0]     data_reg, data_next;

    logic [pmuca_pkg::EVENT_W-1:0]      event_store [pmuca_pkg::MAX_EVENTS];
    logic [pmuca_pkg::EVENT_W-1:0]      entry;
    logic                               s_xfer;
    logic                               m_xfer;
    logic                               store_we;
    logic                               idx_at_end;
    logic [pmuca_pkg::CIDX_W-1:0]       p_field;
    pmuca_pkg::pack_acc_t               unit_acc;
    logic [pmuca_pkg::CIDX_W-1:0]       unit_cidx;
    logic [pmuca_pkg::MMCR0_W-1:0]      unit_mmcr0;

    assign s_tready   = (state_reg == S_COLLECT);
    assign s_xfer     = s_tvalid && s_tready;
    assign m_xfer     = valid_reg && m_tready;
    assign store_we   = s_xfer && (count_reg < pmuca_pkg::CNT_W'(pmuca_pkg::MAX_EVENTS));
    assign entry      = event_store[idx_reg];
    assign p_field    = entry[19:16];
    assign idx_at_end = (pmuca_pkg::CNT_W'(idx_reg) == n_reg - pmuca_pkg::CNT_W'(1));

    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tvalid = valid_reg;

    // event buffer
    always_ff @(posedge aclk) begin
        if (store_we) begin
            event_store[count_reg[pmuca_pkg::IDX_W-1:0]] <= s_tdata[pmuca_pkg::EVENT_W-1:0];
        end
    end

    // shared counter assignment and packing step
    pmuca_pack_unit u_pack (
        .event_code    (entry),
        .acc_in        (acc_reg),
        .acc_out       (unit_acc),
        .counter_index (unit_cidx),
        .mmcr0_image   (unit_mmcr0)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        data_next  = data_reg;

        case (state_reg)
            S_COLLECT: begin
                if (s_xfer) begin
                    if (store_we) begin
                        count_next = count_reg + pmuca_pkg::CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        n_next         = count_next;
                        idx_next       = '0;
                        acc_next.inuse = '0;
                        acc_next.mmcr1 = '0;
                        acc_next.mmcra = pmuca_pkg::MMCRA_INIT;
                        state_next     = S_MARK;
                    end
                end
            end
            S_MARK: begin
                // explicitly named counters
                if (p_field != '0) begin
                    acc_next.inuse = acc_reg.inuse | (16'(1) << p_field);
                end
                if (idx_at_end) begin
                    idx_next   = '0;
                    state_next = S_PACK;
                end else begin
                    idx_next = idx_reg + pmuca_pkg::IDX_W'(1);
                end
            end
            S_PACK: begin
                acc_next   = unit_acc;
                valid_next = 1'b1;
                last_next  = idx_at_end;
                data_next  = {(pmuca_pkg::M_DATA_W - pmuca_pkg::M_FIELDS_W)'(0), ovf_reg,
                              idx_at_end ? unit_acc.mmcra : pmuca_pkg::MMCRA_W'(0),
                              idx_at_end ? unit_acc.mmcr1 : pmuca_pkg::MMCR1_W'(0),
                              idx_at_end ? unit_mmcr0 : pmuca_pkg::MMCR0_W'(0),
                              unit_cidx};
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (m_xfer) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_COLLECT;
                    end else begin
                        idx_next   = idx_reg + pmuca_pkg::IDX_W'(1);
                        state_next = S_PACK;
                    end
                end
            end
            default: begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_COLLECT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        data_reg <= data_next;
    end

    // input and output sides never run together
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    // the final result transfer reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after final result");

    // buffer fill never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pmuca_pkg::CNT_W'(pmuca_pkg::MAX_EVENTS))
        else $error("event count beyond capacity");

    // images stay zero on results before the final one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[163:4] == '0))
        else $error("images present on a non-final result");

    // a set always produces at least one result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (n_reg != '0))
        else $error("empty event set started");

endmodule
